/* design/ps2me_pkg.sv */
// Shared types and constants for the PS/2 mouse device emulator.
// Used by the front, queue, back and top-level modules; no dependencies.
package ps2me_pkg;

    // Input event codes
    typedef enum logic [1:0] {
        OP_HOST_BYTE  = 2'd0,
        OP_USB_REPORT = 2'd1,
        OP_TICK       = 2'd2,
        OP_RESET_DONE = 2'd3
    } ps2me_op_t;

    // Host commands
    localparam logic [7:0] CMD_RESET        = 8'hff;
    localparam logic [7:0] CMD_SET_DEFAULTS = 8'hf6;
    localparam logic [7:0] CMD_DISABLE      = 8'hf5;
    localparam logic [7:0] CMD_ENABLE       = 8'hf4;
    localparam logic [7:0] CMD_SET_RATE     = 8'hf3;
    localparam logic [7:0] CMD_GET_ID       = 8'hf2;
    localparam logic [7:0] CMD_READ_DATA    = 8'heb;
    localparam logic [7:0] CMD_STATUS       = 8'he9;

    // Device replies and packet constants
    localparam logic [7:0] RSP_ACK         = 8'hfa;
    localparam logic [7:0] RSP_SELF_TEST   = 8'haa;
    localparam logic [7:0] BYTE_AVOID_SUB  = 8'hab;
    localparam logic [7:0] STATUS_RES      = 8'h02;
    localparam logic [7:0] PKT_SYNC_BIT    = 8'h08;
    localparam logic [7:0] DEFAULT_RATE    = 8'd100;
    localparam logic [7:0] WHEEL_MIN       = 8'hf8;
    localparam logic [7:0] WHEEL_MAX       = 8'h07;

    // Sample-rate knock sequences
    localparam logic [23:0] KNOCK_WHEEL   = 24'hc86450;
    localparam logic [23:0] KNOCK_BUTTONS = 24'hc8c850;

    // Device IDs
    localparam logic [2:0] ID_PLAIN   = 3'd0;
    localparam logic [2:0] ID_WHEEL   = 3'd3;
    localparam logic [2:0] ID_BUTTONS = 3'd4;

    // One run of reply bytes caused by one input beat
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      nbytes;
        logic [7:0]      rate;
        logic            rpt;
    } ps2me_run_t;

endpackage

/* design/ps2me_front.sv */
// Front part: accepts input beats, updates the mouse state and builds reply runs.
// Depends on ps2me_pkg.
module ps2me_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [1:0]            opcode,
    input  logic [7:0]            host_byte,
    input  logic [7:0]            previous_host_byte,
    input  logic [7:0]            button_bits,
    input  logic signed [7:0]     move_x,
    input  logic signed [7:0]     move_y,
    input  logic signed [7:0]     move_wheel,
    input  logic                  link_busy,
    output logic                  push,
    output ps2me_pkg::ps2me_run_t run
);
    import ps2me_pkg::*;

    logic        rep_en_reg,  rep_en_next;
    logic        moving_reg,  moving_next;
    logic [23:0] hist_reg,    hist_next;
    logic [2:0]  id_reg,      id_next;
    logic [7:0]  rate_reg,    rate_next;
    logic [7:0]  held_reg,    held_next;
    logic [15:0] sum_x_reg,   sum_x_next;
    logic [15:0] sum_y_reg,   sum_y_next;
    logic [7:0]  sum_w_reg,   sum_w_next;
    logic        pending_reg, pending_next;

    // Packet arithmetic on the current sums
    logic              x_lt, x_gt, y_lt, y_gt;
    logic [7:0]        clamp_x, clamp_y;
    logic [15:0]       carry_x, carry_y;
    logic [7:0]        pb1, pb2, pb3, pb4, wb;
    logic signed [8:0] nw;
    logic              pkt_idle;
    logic [23:0]       hist_shift;

    assign x_lt = $signed(sum_x_reg) < -16'sd255;
    assign x_gt = $signed(sum_x_reg) > 16'sd255;
    assign y_lt = $signed(sum_y_reg) < -16'sd255;
    assign y_gt = $signed(sum_y_reg) > 16'sd255;

    assign clamp_x = x_lt ? 8'd1 : (x_gt ? 8'hff : sum_x_reg[7:0]);
    assign clamp_y = y_lt ? 8'd1 : (y_gt ? 8'hff : sum_y_reg[7:0]);
    assign carry_x = x_lt ? sum_x_reg + 16'd255 : (x_gt ? sum_x_reg - 16'd255 : 16'd0);
    assign carry_y = y_lt ? sum_y_reg + 16'd255 : (y_gt ? sum_y_reg - 16'd255 : 16'd0);

    // Header byte: sync bit, buttons, x sign, y sign (y flipped to up-positive)
    assign pb1 = PKT_SYNC_BIT | {5'd0, held_reg[2:0]}
               | {3'd0, sum_x_reg[15], 4'd0}
               | {2'd0, (~sum_y_reg[15] & (|sum_y_reg)), 5'd0};
    assign pb2 = (clamp_x == RSP_SELF_TEST) ? BYTE_AVOID_SUB : clamp_x;
    assign pb3 = ((8'd0 - clamp_y) == RSP_SELF_TEST) ? BYTE_AVOID_SUB : (8'd0 - clamp_y);

    // Wheel: negate in 9 bits, clamp to a 4-bit signed range
    assign nw = 9'sd0 - $signed({sum_w_reg[7], sum_w_reg});
    assign wb = (nw < -9'sd8) ? WHEEL_MIN : ((nw > 9'sd7) ? WHEEL_MAX : nw[7:0]);
    assign pb4 = (id_reg == ID_BUTTONS) ? {2'd0, held_reg[4], held_reg[3], wb[3:0]} : wb;

    assign pkt_idle = (held_reg == 8'd0) && (sum_x_reg == 16'd0)
                    && (sum_y_reg == 16'd0) && (sum_w_reg == 8'd0);
    assign hist_shift = {hist_reg[15:0], host_byte};

    // Next state and reply run for the beat on the inputs
    always_comb
    begin
        rep_en_next  = rep_en_reg;
        moving_next  = moving_reg;
        hist_next    = hist_reg;
        id_next      = id_reg;
        rate_next    = rate_reg;
        held_next    = held_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        sum_w_next   = sum_w_reg;
        pending_next = pending_reg;
        run.data     = '0;
        run.nbytes   = 3'd0;

        case (ps2me_op_t'(opcode))
            OP_HOST_BYTE:
            begin
                run.data[0] = RSP_ACK;
                run.nbytes  = 3'd1;
                if (previous_host_byte == CMD_SET_RATE)
                begin
                    rate_next = host_byte;
                    hist_next = hist_shift;
                    if (id_reg == ID_PLAIN && hist_shift == KNOCK_WHEEL)
                        id_next = ID_WHEEL;
                    else if (id_reg == ID_WHEEL && hist_shift == KNOCK_BUTTONS)
                        id_next = ID_BUTTONS;
                    moving_next = 1'b0;
                    held_next   = 8'd0;
                    sum_x_next  = 16'd0;
                    sum_y_next  = 16'd0;
                    sum_w_next  = 8'd0;
                end
                else
                begin
                    case (host_byte)
                        CMD_RESET:
                        begin
                            pending_next = 1'b1;
                            id_next      = ID_PLAIN;
                            rate_next    = DEFAULT_RATE;
                            rep_en_next  = 1'b0;
                        end
                        CMD_SET_DEFAULTS:
                        begin
                            rate_next   = DEFAULT_RATE;
                            rep_en_next = 1'b0;
                        end
                        CMD_DISABLE: rep_en_next = 1'b0;
                        CMD_ENABLE:  rep_en_next = 1'b1;
                        CMD_GET_ID:
                        begin
                            run.data[1] = {5'd0, id_reg};
                            run.nbytes  = 3'd2;
                        end
                        CMD_STATUS:
                        begin
                            run.data[1] = {2'd0, rep_en_reg, 5'd0};
                            run.data[2] = STATUS_RES;
                            run.data[3] = rate_reg;
                            run.nbytes  = 3'd4;
                        end
                        default: ;
                    endcase
                    // Every command except read data and status drops motion
                    if (host_byte == CMD_READ_DATA)
                        moving_next = 1'b1;
                    else if (host_byte != CMD_STATUS)
                    begin
                        moving_next = 1'b0;
                        held_next   = 8'd0;
                        sum_x_next  = 16'd0;
                        sum_y_next  = 16'd0;
                        sum_w_next  = 8'd0;
                    end
                end
            end
            OP_USB_REPORT:
            begin
                held_next  = button_bits;
                sum_x_next = sum_x_reg + {{8{move_x[7]}}, move_x};
                sum_y_next = sum_y_reg + {{8{move_y[7]}}, move_y};
                sum_w_next = sum_w_reg + move_wheel;
            end
            OP_TICK:
            begin
                if (rep_en_reg && !link_busy)
                begin
                    sum_x_next = carry_x;
                    sum_y_next = carry_y;
                    sum_w_next = 8'd0;
                    if (!pkt_idle || moving_reg)
                    begin
                        moving_next = !pkt_idle;
                        run.data[0] = pb1;
                        run.data[1] = pb2;
                        run.data[2] = pb3;
                        run.data[3] = pb4;
                        run.nbytes  = (id_reg == ID_WHEEL || id_reg == ID_BUTTONS)
                                    ? 3'd4 : 3'd3;
                    end
                end
            end
            OP_RESET_DONE:
            begin
                if (pending_reg)
                begin
                    pending_next = 1'b0;
                    run.data[0]  = RSP_SELF_TEST;
                    run.data[1]  = {5'd0, id_reg};
                    run.nbytes   = 3'd2;
                end
            end
            default: ;
        endcase

        run.rate = rate_next;
        run.rpt  = rep_en_next;
    end

    assign push = accept && (run.nbytes != 3'd0);

    // Hold state; advance only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_en_reg  <= 1'b0;
            moving_reg  <= 1'b0;
            hist_reg    <= 24'd0;
            id_reg      <= ID_PLAIN;
            rate_reg    <= DEFAULT_RATE;
            held_reg    <= 8'd0;
            sum_x_reg   <= 16'd0;
            sum_y_reg   <= 16'd0;
            sum_w_reg   <= 8'd0;
            pending_reg <= 1'b1;
        end
        else if (accept)
        begin
            rep_en_reg  <= rep_en_next;
            moving_reg  <= moving_next;
            hist_reg    <= hist_next;
            id_reg      <= id_next;
            rate_reg    <= rate_next;
            held_reg    <= held_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            sum_w_reg   <= sum_w_next;
            pending_reg <= pending_next;
        end
    end

endmodule

/* design/ps2me_queue.sv */
// Short queue of reply runs between the front and back parts.
// Depends on ps2me_pkg.
module ps2me_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ps2me_pkg::ps2me_run_t push_run,
    input  logic                  pop,
    output ps2me_pkg::ps2me_run_t head_run,
    output logic                  head_valid,
    output logic                  full
);
    import ps2me_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ps2me_run_t      slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_run   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed run
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_run;
    end

endmodule

/* design/ps2me_back.sv */
// Back part: walks the head run byte by byte into the output register.
// Depends on ps2me_pkg.
module ps2me_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ps2me_pkg::ps2me_run_t head_run,
    input  logic                  head_valid,
    output logic                  pop,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  last_of_run,
    output logic [7:0]            sample_rate,
    output logic                  reporting_on
);
    import ps2me_pkg::*;

    logic [1:0] idx_reg,   idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [7:0] rate_reg;
    logic       rpt_reg;
    logic       load;
    logic       is_last;

    assign load    = head_valid && (!valid_reg || !out_stall);
    assign is_last = ({1'b0, idx_reg} == (head_run.nbytes - 3'd1));
    assign pop     = load && is_last;

    // Step through the run; drop the output beat once taken
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= head_run.data[idx_reg];
            last_reg <= is_last;
            rate_reg <= head_run.rate;
            rpt_reg  <= head_run.rpt;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign last_of_run  = last_reg;
    assign sample_rate  = rate_reg;
    assign reporting_on = rpt_reg;

endmodule

/* design/ps2_mouse_device_emulator_top.sv */
// PS/2 mouse device emulator, device side with wheel and 5-button extensions.
// An input beat is taken every cycle while the reply queue has room; each beat
// updates the mouse state at once and queues its reply bytes, if any (one to four), as
// one run. Reply bytes leave one per cycle through a registered output while
// out_stall is low, and the reply queue (QUEUE_DEPTH runs, range 2 and up) sets
// how far input can run ahead of output. Depends on ps2me_pkg, ps2me_front,
// ps2me_queue, ps2me_back.
module ps2_mouse_device_emulator_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [7:0]        host_byte,
    input  logic [7:0]        previous_host_byte,
    input  logic [7:0]        button_bits,
    input  logic signed [7:0] move_x,
    input  logic signed [7:0] move_y,
    input  logic signed [7:0] move_wheel,
    input  logic              link_busy,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              last_of_run,
    output logic [7:0]        sample_rate,
    output logic              reporting_on
);
    import ps2me_pkg::*;

    logic       accept;
    logic       push;
    logic       pop;
    logic       head_valid;
    logic       full;
    ps2me_run_t push_run;
    ps2me_run_t head_run;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Accept and classify beats
    ps2me_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .opcode             (opcode),
        .host_byte          (host_byte),
        .previous_host_byte (previous_host_byte),
        .button_bits        (button_bits),
        .move_x             (move_x),
        .move_y             (move_y),
        .move_wheel         (move_wheel),
        .link_busy          (link_busy),
        .push               (push),
        .run                (push_run)
    );

    // Buffer reply runs
    ps2me_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_run   (push_run),
        .pop        (pop),
        .head_run   (head_run),
        .head_valid (head_valid),
        .full       (full)
    );

    // Serialize reply bytes
    ps2me_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_run     (head_run),
        .head_valid   (head_valid),
        .pop          (pop),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run),
        .sample_rate  (sample_rate),
        .reporting_on (reporting_on)
    );

endmodule
